// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the line raster RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lrg_pkg.sv -----
// Types and constants of the line raster generator
package lrg_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef struct packed {
        t_action action;
        t_coord  ax;
        t_coord  ay;
        t_coord  bx;
        t_coord  by;
    } t_cmd;

    typedef struct packed {
        logic   pixel_valid;
        t_coord px;
        t_coord py;
        logic   last;
    } t_pix;

    function automatic t_err to_err(input t_coord v);
        return $signed({{(ERR_BITS-COORD_BITS){1'b0}}, v});
    endfunction

endpackage

// ----- hw/rtl/lrg_ifs.sv -----
// Handshake channels of the line raster generator
interface lrg_in_if;
    import lrg_pkg::*;
    logic    valid;
    logic    ready;
    t_action action;
    t_coord  ax;
    t_coord  ay;
    t_coord  bx;
    t_coord  by;

    modport source (output valid, action, ax, ay, bx, by, input ready);
    modport sink   (input valid, action, ax, ay, bx, by, output ready);
endinterface

interface lrg_out_if;
    import lrg_pkg::*;
    logic   valid;
    logic   ready;
    logic   pixel_valid;
    t_coord px;
    t_coord py;
    logic   last;

    modport source (output valid, pixel_valid, px, py, last, input ready);
    modport sink   (input valid, pixel_valid, px, py, last, output ready);
endinterface

// ----- hw/rtl/lrg_core.sv -----
// Line state registers and the per-transaction Bresenham step
`include "assert_macros.svh"

module lrg_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  lrg_pkg::t_cmd i_cmd,
    output lrg_pkg::t_pix o_pix
);
    import lrg_pkg::*;

    logic   r_active,     n_active;
    t_coord r_cur_x,      n_cur_x;
    t_coord r_cur_y,      n_cur_y;
    t_coord r_major_end,  n_major_end;
    t_coord r_delta_x,    n_delta_x;
    t_coord r_delta_y,    n_delta_y;
    t_err   r_error_term, n_error_term;
    logic   r_x_is_major, n_x_is_major;
    logic   r_minor_down, n_minor_down;

    t_coord w_dx, w_dy;
    logic   w_xmaj, w_swap;
    t_coord w_sx, w_sy, w_fx, w_fy, w_send;
    t_coord w_cmaj, w_cmin, w_dmaj, w_dmin, w_cmaj_nx, w_cmin_nx;
    logic   w_fin;

    always_comb begin
        n_active     = r_active;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_major_end  = r_major_end;
        n_delta_x    = r_delta_x;
        n_delta_y    = r_delta_y;
        n_error_term = r_error_term;
        n_x_is_major = r_x_is_major;
        n_minor_down = r_minor_down;
        o_pix        = '0;

        w_dx   = (i_cmd.ax > i_cmd.bx) ? i_cmd.ax - i_cmd.bx : i_cmd.bx - i_cmd.ax;
        w_dy   = (i_cmd.ay > i_cmd.by) ? i_cmd.ay - i_cmd.by : i_cmd.by - i_cmd.ay;
        w_xmaj = w_dx > w_dy;
        w_swap = w_xmaj ? (i_cmd.ax > i_cmd.bx) : (i_cmd.ay > i_cmd.by);
        w_sx   = w_swap ? i_cmd.bx : i_cmd.ax;
        w_sy   = w_swap ? i_cmd.by : i_cmd.ay;
        w_fx   = w_swap ? i_cmd.ax : i_cmd.bx;
        w_fy   = w_swap ? i_cmd.ay : i_cmd.by;
        w_send = w_xmaj ? w_fx : w_fy;

        w_cmaj    = r_x_is_major ? r_cur_x : r_cur_y;
        w_cmin    = r_x_is_major ? r_cur_y : r_cur_x;
        w_dmaj    = r_x_is_major ? r_delta_x : r_delta_y;
        w_dmin    = r_x_is_major ? r_delta_y : r_delta_x;
        w_cmaj_nx = w_cmaj + COORD_BITS'(1);
        w_cmin_nx = w_cmin;
        w_fin     = 1'b0;

        case (i_cmd.action)
            ACT_START: begin
                n_delta_x    = w_dx;
                n_delta_y    = w_dy;
                n_x_is_major = w_xmaj;
                n_cur_x      = w_sx;
                n_cur_y      = w_sy;
                n_major_end  = w_send;
                n_minor_down = w_xmaj ? (w_fy < w_sy) : (w_fx < w_sx);
                n_error_term = w_xmaj ? (to_err(w_dy) <<< 1) - to_err(w_dx)
                                      : (to_err(w_dx) <<< 1) - to_err(w_dy);
                w_fin        = (w_xmaj ? w_sx : w_sy) == w_send;
                n_active     = !w_fin;
                o_pix        = '{pixel_valid: 1'b1, px: w_sx, py: w_sy, last: w_fin};
            end
            ACT_STEP: begin
                if (r_active) begin
                    if (r_error_term < 0) begin
                        n_error_term = r_error_term + (to_err(w_dmin) <<< 1);
                    end else begin
                        w_cmin_nx    = r_minor_down ? w_cmin - COORD_BITS'(1)
                                                    : w_cmin + COORD_BITS'(1);
                        n_error_term = r_error_term + (to_err(w_dmin) <<< 1)
                                       - (to_err(w_dmaj) <<< 1);
                    end
                    n_cur_x  = r_x_is_major ? w_cmaj_nx : w_cmin_nx;
                    n_cur_y  = r_x_is_major ? w_cmin_nx : w_cmaj_nx;
                    w_fin    = w_cmaj_nx == r_major_end;
                    n_active = !w_fin;
                    o_pix    = '{pixel_valid: 1'b1, px: n_cur_x, py: n_cur_y, last: w_fin};
                end
            end
            default: begin
                o_pix = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_major_end  <= '0;
            r_delta_x    <= '0;
            r_delta_y    <= '0;
            r_error_term <= '0;
            r_x_is_major <= 1'b0;
            r_minor_down <= 1'b0;
        end else if (i_fire) begin
            r_active     <= n_active;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_major_end  <= n_major_end;
            r_delta_x    <= n_delta_x;
            r_delta_y    <= n_delta_y;
            r_error_term <= n_error_term;
            r_x_is_major <= n_x_is_major;
            r_minor_down <= n_minor_down;
        end
    end

    `ASSERT_ANY(a_reset_idle, !i_rst_n |=> !r_active, "line active after reset")
    `ASSERT_CLK(a_last_ends, i_fire && o_pix.last |=> !r_active, "line active after last pixel")
    `ASSERT_CLK(a_mid_keeps, i_fire && o_pix.pixel_valid && !o_pix.last |=> r_active,
                "line dropped before last pixel")
    `ASSERT_CLK(a_hold_state, !i_fire |=> $stable(r_active) && $stable(r_cur_x) &&
                $stable(r_cur_y) && $stable(r_error_term), "line state moved without transaction")

endmodule

// ----- hw/rtl/line_raster_generator.sv -----
// Top level of the line raster generator: input and result registers around the step core
//
//  channel  dir  payload                          role
//  i_cmd    in   action, ax, ay, bx, by           start a line or ask for the next pixel
//  o_pix    out  pixel_valid, px, py, last        one result per command
//
//  One command per cycle unless o_pix stalls; input register, then result register.
//  The rate is set by the line state loop: one add and compare on the error term per cycle.
//  Reset clears the channel valid flags and the line state; no line is active afterwards.
//  A stalled result holds in the result register; one more command waits in the input register.
module line_raster_generator (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lrg_in_if.sink   i_cmd,
    lrg_out_if.source o_pix
);
    import lrg_pkg::*;

    logic r_in_vld;
    t_cmd r_cmd;
    logic r_out_vld;
    t_pix r_pix;
    t_pix w_pix;
    logic w_out_free;
    logic w_move;

    assign w_out_free  = !r_out_vld || o_pix.ready;
    assign w_move      = r_in_vld && w_out_free;
    assign i_cmd.ready = !r_in_vld || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_vld <= i_cmd.valid;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= '{action: i_cmd.action, ax: i_cmd.ax, ay: i_cmd.ay,
                       bx: i_cmd.bx, by: i_cmd.by};
        end
        if (w_move) begin
            r_pix <= w_pix;
        end
    end

    lrg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_move),
        .i_cmd   (r_cmd),
        .o_pix   (w_pix)
    );

    assign o_pix.valid       = r_out_vld;
    assign o_pix.pixel_valid = r_pix.pixel_valid;
    assign o_pix.px          = r_pix.px;
    assign o_pix.py          = r_pix.py;
    assign o_pix.last        = r_pix.last;

endmodule
